// File: design/spds_pkg.sv
// Shared types and constants for the sorted dictionary prefix search core.
// No dependencies; every other design file but spds_word_mem refers to it by scoped names.
`default_nettype none

package spds_pkg;

    // Default table geometry
    localparam int SPDS_MAX_ENTRIES = 16;
    localparam int SPDS_MAX_CHARS   = 32;

    // Fixed field widths
    localparam int CNT_W       = 5;
    localparam int IDX_W       = 4;
    localparam int POS_W       = 5;
    localparam int CHAR_W      = 8;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 8;

    // Per-entry order status
    typedef logic [1:0] t_status;
    localparam t_status ST_EQUAL         = 2'd0;
    localparam t_status ST_QUERY_LESS    = 2'd1;
    localparam t_status ST_QUERY_GREATER = 2'd2;

    // Control from the sequencer to the order unit
    typedef struct packed {
        logic cmp_en;   // compare table byte against query byte
        logic beyond;   // query position past the word width: table byte reads as zero
        logic clear;    // end of query: all entries back to equal
    } t_ord_ctl;

endpackage

`default_nettype wire

// File: design/spds_word_mem.sv
// Word table memory: one write port, one registered read port, zero sweep after reset.
// Depends on nothing but its parameters.
`default_nettype none

module spds_word_mem #(
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [7:0]    i_wr_data,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output logic      [7:0]    o_rd_data,
    output logic               o_clr_busy
);

    logic [7:0]    r_mem [DEPTH];
    logic [7:0]    r_rd_data;
    logic [AW-1:0] r_clr_addr;
    logic          r_clr_busy;
    logic          wen;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;

    // sweep has priority; the sequencer takes no word while it runs
    assign wen   = r_clr_busy | i_wr_en;
    assign waddr = r_clr_busy ? r_clr_addr : i_wr_addr;
    assign wdata = r_clr_busy ? 8'd0 : i_wr_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wen) begin
            r_mem[waddr] <= wdata;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_clr_busy = r_clr_busy;

endmodule

`default_nettype wire

// File: design/spds_order_unit.sv
// Shared byte comparator and per-entry order status registers.
// Depends on spds_pkg for status codes and the control struct.
`default_nettype none

module spds_order_unit #(
    parameter int MAX_ENTRIES = spds_pkg::SPDS_MAX_ENTRIES,
    parameter int EW          = 4
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire spds_pkg::t_ord_ctl       i_ctl,
    input  wire logic [EW-1:0]            i_idx,
    input  wire logic [7:0]               i_query_char,
    input  wire logic [7:0]               i_tbl_char,
    output spds_pkg::t_status             o_status
);

    spds_pkg::t_status r_status [MAX_ENTRIES];
    spds_pkg::t_status cur;
    spds_pkg::t_status upd;
    logic [7:0]        tbl;
    logic              differ;

    assign cur    = r_status[i_idx];
    assign tbl    = i_ctl.beyond ? 8'd0 : i_tbl_char;
    assign differ = (tbl != i_query_char);
    // an entry that ends first, or holds a smaller byte, sorts before the query
    assign upd    = ((tbl == 8'd0) || (i_query_char > tbl)) ? spds_pkg::ST_QUERY_GREATER
                                                            : spds_pkg::ST_QUERY_LESS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            for (int e = 0; e < MAX_ENTRIES; e++) begin
                r_status[e] <= spds_pkg::ST_EQUAL;
            end
        end else if (i_ctl.cmp_en && (cur == spds_pkg::ST_EQUAL) && differ) begin
            r_status[i_idx] <= upd;
        end
    end

    assign o_status = cur;

endmodule

`default_nettype wire

// File: design/sorted_dictionary_prefix_search_core.sv
// Top level of the sorted dictionary prefix search core: sequencer, output register.
// Depends on spds_pkg, spds_word_mem and spds_order_unit.
//
//   channel   | direction | fields (lowest bit first)
//   ----------+-----------+-------------------------------------------------------------
//   s_axis    | in        | tuser = mode; tdata = entry_index, char_position, character
//   m_axis    | out       | tdata = found
//   i_cfg_wr  | in        | wr_data = entry_count
//
// A load word leaves the sequencer idle. For a query byte, the entries are read one per
// cycle through the single read port of the word table and checked by one shared
// comparator. A terminator runs an in-order scan of the status registers over up to
// min(entry_count, MAX_ENTRIES) entries, plus any wait for the output register. Reset
// clears the word table in a sweep over all MAX_ENTRIES * MAX_CHARS addresses (512 by
// default); s_axis_tready stays low through the sweep and until the sequencer leaves
// its clear state. Configuration writes are taken throughout. A result waits in the
// output register while the next words are taken; only a new result waits for it to
// drain.
`default_nettype none

module sorted_dictionary_prefix_search_core #(
    parameter int MAX_ENTRIES = spds_pkg::SPDS_MAX_ENTRIES,
    parameter int MAX_CHARS   = spds_pkg::SPDS_MAX_CHARS
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_wr_en,
    input  wire logic [spds_pkg::CNT_W-1:0]       i_cfg_wr_data,   // entry_count
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [3:0] entry_index, [8:4] char_position, [16:9] character, [23:17] zero
    input  wire logic [spds_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  wire logic                             s_axis_tuser,    // mode
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    output logic [spds_pkg::OUT_TDATA_W-1:0]      m_axis_tdata     // [0] found, [7:1] zero
);

    localparam int EW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int SW    = $clog2(MAX_ENTRIES + 1);
    localparam int PW    = $clog2(MAX_CHARS + 1);
    localparam int DEPTH = MAX_ENTRIES * MAX_CHARS;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_CMP   = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    // control state
    logic [2:0]                 r_state, n_state;
    logic [PW-1:0]              r_qpos;
    logic                       r_cmp_vld;
    logic                       r_out_vld;
    logic [spds_pkg::CNT_W-1:0] r_entry_count;

    // payload
    logic [7:0]                 r_char;
    logic [EW-1:0]              r_issue;
    logic [EW-1:0]              r_cmp_idx;
    logic [SW-1:0]              r_scan;
    logic [SW-1:0]              r_limit;
    logic                       r_found;
    logic                       r_out_found;

    logic                       in_acc;
    logic                       in_mode;
    logic [spds_pkg::IDX_W-1:0] in_idx;
    logic [spds_pkg::POS_W-1:0] in_pos;
    logic [7:0]                 in_char;
    logic                       load_ok;
    logic                       mem_wr_en;
    logic [AW-1:0]              mem_wr_addr;
    logic [AW-1:0]              mem_rd_addr;
    logic [7:0]                 mem_rd_data;
    logic                       clr_busy;
    logic                       beyond;
    logic                       out_free;
    logic                       scan_end;
    logic                       scan_hit;
    logic                       scan_stop;
    logic [EW-1:0]              ord_idx;
    spds_pkg::t_ord_ctl         ord_ctl;
    spds_pkg::t_status          ord_status;

    // unpack the input word
    assign in_mode = s_axis_tuser;
    assign in_idx  = s_axis_tdata[3:0];
    assign in_pos  = s_axis_tdata[8:4];
    assign in_char = s_axis_tdata[16:9];

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid & s_axis_tready;

    // drop loads that fall outside the table
    assign load_ok     = (int'(in_idx) < MAX_ENTRIES) && (int'(in_pos) < MAX_CHARS);
    assign mem_wr_en   = in_acc & ~in_mode & load_ok;
    assign mem_wr_addr = AW'(in_idx) * AW'(MAX_CHARS) + AW'(in_pos);

    // query positions past the word width compare as terminator
    assign beyond      = (r_qpos == PW'(MAX_CHARS));
    assign mem_rd_addr = AW'(r_issue) * AW'(MAX_CHARS) + AW'(r_qpos);

    assign out_free  = ~r_out_vld | m_axis_tready;

    // scan decides on the first equal entry (found), or the first greater entry or the count limit (not found)
    assign scan_end  = (r_scan >= r_limit);
    assign scan_hit  = ~scan_end && (ord_status == spds_pkg::ST_EQUAL);
    assign scan_stop = scan_end || (ord_status == spds_pkg::ST_EQUAL)
                                || (ord_status == spds_pkg::ST_QUERY_LESS);

    assign ord_idx        = (r_state == S_SCAN) ? r_scan[EW-1:0] : r_cmp_idx;
    assign ord_ctl.cmp_en = r_cmp_vld;
    assign ord_ctl.beyond = beyond;
    assign ord_ctl.clear  = (r_state == S_DONE) && out_free;

    spds_word_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (mem_wr_en),
        .i_wr_addr  (mem_wr_addr),
        .i_wr_data  (in_char),
        .i_rd_en    (r_state == S_CMP),
        .i_rd_addr  (mem_rd_addr),
        .o_rd_data  (mem_rd_data),
        .o_clr_busy (clr_busy)
    );

    spds_order_unit #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .EW          (EW)
    ) u_ord (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (ord_ctl),
        .i_idx        (ord_idx),
        .i_query_char (r_char),
        .i_tbl_char   (mem_rd_data),
        .o_status     (ord_status)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (!clr_busy) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (in_acc && in_mode) begin
                    n_state = (in_char != 8'd0) ? S_CMP : S_SCAN;
                end
            end
            S_CMP: begin
                // last entry issued: let its compare land
                if (r_issue == EW'(MAX_ENTRIES - 1)) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                n_state = S_IDLE;
            end
            S_SCAN: begin
                if (scan_stop) n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_qpos        <= '0;
            r_cmp_vld     <= 1'b0;
            r_out_vld     <= 1'b0;
            r_entry_count <= '0;
        end else begin
            if (i_cfg_wr_en) r_entry_count <= i_cfg_wr_data;
            r_state   <= n_state;
            r_cmp_vld <= (r_state == S_CMP);
            // advance the query position once all entries have seen the byte; saturate
            if ((r_state == S_DRAIN) && !beyond) begin
                r_qpos <= r_qpos + 1'b1;
            end else if (ord_ctl.clear) begin
                r_qpos <= '0;
            end
            if (ord_ctl.clear) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_char  <= in_char;
            r_issue <= '0;
            r_scan  <= '0;
            // counts above the table size scan every entry
            r_limit <= (int'(r_entry_count) < MAX_ENTRIES) ? SW'(r_entry_count)
                                                           : SW'(MAX_ENTRIES);
        end
        if (r_state == S_CMP) begin
            r_issue   <= r_issue + 1'b1;
            r_cmp_idx <= r_issue;
        end
        if (r_state == S_SCAN) begin
            if (scan_stop) begin
                r_found <= scan_hit;
            end else begin
                r_scan <= r_scan + 1'b1;
            end
        end
        if (ord_ctl.clear) r_out_found <= r_found;
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {(spds_pkg::OUT_TDATA_W - 1)'(0), r_out_found};

endmodule

`default_nettype wire

// File: design/spds_checker.sv
// Port-level checks for the prefix search core, attached by the bind below.
// Depends on spds_pkg for port widths.
`default_nettype none

module spds_checker (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             s_axis_tvalid,
    input wire logic                             s_axis_tready,
    input wire logic                             s_axis_tuser,
    input wire logic                             m_axis_tvalid,
    input wire logic                             m_axis_tready,
    input wire logic [spds_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    logic in_acc;
    assign in_acc = s_axis_tvalid & s_axis_tready;

    // a held result keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // any accepted query word, byte or terminator, holds off the input after it
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && s_axis_tuser |=> !s_axis_tready)
        else $error("ready during query processing");

    // a table load leaves the input ready straight after it
    a_load_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !s_axis_tuser |=> s_axis_tready)
        else $error("not ready after table load");

    // only the found bit carries information
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[spds_pkg::OUT_TDATA_W-1:1] == '0))
        else $error("result padding not zero");

endmodule

bind sorted_dictionary_prefix_search_core spds_checker u_spds_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// File: test/sorted_dictionary_prefix_search_core_test.sv
`timescale 1ns / 1ps
// Self-checking bench for sorted_dictionary_prefix_search_core: streams table loads and
// queries, predicts every found word and checks it. Depends on spds_pkg and the core RTL.

module sorted_dictionary_prefix_search_core_test;

    localparam int NE = spds_pkg::SPDS_MAX_ENTRIES;
    localparam int NC = spds_pkg::SPDS_MAX_CHARS;

    // tuser codes
    localparam bit MODE_LOAD  = 1'b0;
    localparam bit MODE_QUERY = 1'b1;

    localparam logic [7:0] CH_END = 8'h00;  // ends a table word or a query
    localparam logic [7:0] CH_A   = 8'h61;  // base of the small alphabet used for words

    // Settle time covers two of the longest query bytes, with slack on top.
    localparam int SETTLE_CYCLES = 2 * (NE + 2) + 8;
    localparam int HOLD_CYCLES   = 900;
    localparam int CYCLE_LIMIT   = 400000;

    typedef struct packed {
        logic       mode;
        logic [3:0] idx;
        logic [4:0] pos;
        logic [7:0] ch;
    } t_in_item;

    // ------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    logic                             i_cfg_wr_en   = 1'b0;
    logic [spds_pkg::CNT_W-1:0]       i_cfg_wr_data = '0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [spds_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;  // [3:0] idx, [8:4] pos, [16:9] char
    logic                             s_axis_tuser  = 1'b0; // mode
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [spds_pkg::OUT_TDATA_W-1:0] m_axis_tdata;         // [0] found

    sorted_dictionary_prefix_search_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // ------------------------------------------------------------------
    // Shared bench state
    // ------------------------------------------------------------------
    t_in_item   pending_in_q[$];       // words waiting for the driver
    bit         expected_found_q[$];   // predicted found bits, oldest first
    t_in_item   next_in;
    int         tx_idle_pct  = 0;
    int         rx_idle_pct  = 0;
    bit         hold_go      = 1'b0;
    logic       hold_active  = 1'b0;
    int         fail_count   = 0;
    int         cycle_cnt    = 0;
    int         gen_count    = 0;

    // Predictor copy of the block: table, per-entry order, query position, entry count.
    bit [7:0]           model_tab [NE][NC];
    spds_pkg::t_status  model_status [NE];
    int                 model_qpos  = 0;
    bit [4:0]           model_count = '0;

    // Table contents as the generator will have left them, used to build matching queries.
    bit [7:0]   plan_tab [NE][NC];

    // ------------------------------------------------------------------
    // Predictor: apply one accepted word, push a found bit on a terminator
    // ------------------------------------------------------------------
    function automatic void search_model_step(bit mode, bit [3:0] idx, bit [4:0] pos,
                                              bit [7:0] ch);
        bit [7:0] tbyte;
        int       lim;
        bit       hit;
        if (mode == MODE_LOAD) begin
            model_tab[idx][pos] = ch;
            return;
        end
        if (ch != CH_END) begin
            // Only entries still equal get refined; past the word width the table reads zero.
            for (int e = 0; e < NE; e++) begin
                if (model_status[e] == spds_pkg::ST_EQUAL) begin
                    tbyte = (model_qpos < NC) ? model_tab[e][model_qpos] : CH_END;
                    if (tbyte != ch)
                        model_status[e] = (tbyte == CH_END || ch > tbyte) ?
                                          spds_pkg::ST_QUERY_GREATER :
                                          spds_pkg::ST_QUERY_LESS;
                end
            end
            if (model_qpos < NC)
                model_qpos++;
            return;
        end
        // Terminator: in-order scan, first equal entry hits, first larger entry stops.
        lim = (model_count < NE) ? model_count : NE;
        hit = 1'b0;
        for (int e = 0; e < lim; e++) begin
            if (model_status[e] == spds_pkg::ST_EQUAL) begin
                hit = 1'b1;
                break;
            end
            if (model_status[e] == spds_pkg::ST_QUERY_LESS)
                break;
        end
        expected_found_q.push_back(hit);
        foreach (model_status[e])
            model_status[e] = spds_pkg::ST_EQUAL;
        model_qpos = 0;
    endfunction

    function automatic void log_failure(string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", msg);
    endfunction

    // ------------------------------------------------------------------
    // Driver: predict on each accepted word, then offer the next pending one
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            search_model_step(s_axis_tuser, s_axis_tdata[3:0], s_axis_tdata[8:4],
                              s_axis_tdata[16:9]);
        // Hold the current word until it is taken; a free slot may idle at random.
        if (!s_axis_tvalid || s_axis_tready) begin
            if (i_rst_n && pending_in_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                next_in = pending_in_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {7'd0, next_in.ch, next_in.pos, next_in.idx};
                s_axis_tuser  <= next_in.mode;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each result word against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_found_q.size() == 0) begin
                log_failure($sformatf("unexpected result: tdata 0x%02h", m_axis_tdata));
            end else if (m_axis_tdata !== {7'd0, expected_found_q[0]}) begin
                log_failure($sformatf("found mismatch: expected %0d, got tdata 0x%02h",
                                      expected_found_q[0], m_axis_tdata));
                void'(expected_found_q.pop_front());
            end else begin
                void'(expected_found_q.pop_front());
            end
        end
        m_axis_tready <= !hold_active && ($urandom_range(99) >= rx_idle_pct);
    end

    // Long receiver hold-off, counted here so the sender keeps pushing and the core backs up.
    initial begin
        wait (hold_go);
        @(posedge i_clk);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_active <= 1'b0;
    end

    // Watchdog
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("FAIL sorted_dictionary_prefix_search_core");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus builders (zero time; called at a falling edge)
    // ------------------------------------------------------------------
    function automatic void push_item(bit mode, int idx, int pos, int ch);
        t_in_item it;
        it.mode = mode;
        it.idx  = idx[3:0];
        it.pos  = pos[4:0];
        it.ch   = ch[7:0];
        pending_in_q.push_back(it);
        if (mode == MODE_LOAD)
            plan_tab[it.idx][it.pos] = it.ch;
        gen_count++;
    endfunction

    function automatic void push_noise_load();
        push_item(MODE_LOAD, $urandom_range(NE - 1), $urandom_range(NC - 1),
                  $urandom_range(255));
    endfunction

    // Write one word into an entry; now and then a full-width word with no terminator.
    function automatic void load_word(int idx);
        int len;
        len = ($urandom_range(99) < 8) ? NC : $urandom_range(0, 5);
        for (int p = 0; p < len; p++)
            push_item(MODE_LOAD, idx, p, CH_A + $urandom_range(0, 3));
        if (len < NC)
            push_item(MODE_LOAD, idx, len, CH_END);
    endfunction

    // Fill entries 0..n-1 with words in ascending order. A word is up to 4 letters, coded
    // as base-5 digits with 0 for the end, so numeric order equals dictionary order.
    function automatic void load_sorted_table(int n);
        int keys[$];
        int k, len, tmp, j, div, d, p;
        for (int i = 0; i < n; i++) begin
            len = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 4);
            k = 0;
            for (int q = 0; q < 4; q++)
                k = k * 5 + ((q < len) ? $urandom_range(1, 4) : 0);
            keys.push_back(k);
        end
        for (int i = 1; i < n; i++) begin
            tmp = keys[i];
            j = i - 1;
            while (j >= 0 && keys[j] > tmp) begin
                keys[j + 1] = keys[j];
                j--;
            end
            keys[j + 1] = tmp;
        end
        for (int i = 0; i < n; i++) begin
            div = 125;
            p = 0;
            d = (keys[i] / div) % 5;
            while (div > 0 && d != 0) begin
                push_item(MODE_LOAD, i, p, CH_A + d - 1);
                p++;
                div = div / 5;
                d = (div > 0) ? (keys[i] / div) % 5 : 0;
            end
            push_item(MODE_LOAD, i, p, CH_END);
        end
    endfunction

    // One query: a prefix of a table word (sometimes bent), a short random string, random
    // bytes, or a long run that can reach past the word width. Loads now and then land mid-query.
    function automatic void push_query();
        int kind, e, wl, len, ch;
        kind = $urandom_range(99);
        e    = $urandom_range(NE - 1);
        wl   = 0;
        while (wl < NC && plan_tab[e][wl] != CH_END)
            wl++;
        if (kind < 45)
            len = $urandom_range(0, wl);
        else if (kind < 75)
            len = $urandom_range(0, 5);
        else if (kind < 90)
            len = $urandom_range(0, 4);
        else
            len = $urandom_range(NC - 2, NC + 4);
        for (int p = 0; p < len; p++) begin
            if (kind < 45) begin
                ch = plan_tab[e][p];
                if (p == len - 1 && $urandom_range(3) == 0)
                    ch = ($urandom_range(1)) ? ch + 1 : ch - 1;
            end else if (kind < 75) begin
                ch = CH_A + $urandom_range(0, 3);
            end else if (kind < 90) begin
                ch = $urandom_range(1, 255);
            end else begin
                ch = (p < NC && plan_tab[e][p] != CH_END) ? plan_tab[e][p]
                                                          : CH_A + $urandom_range(0, 3);
            end
            ch = ch & 8'hFF;
            if (ch == CH_END)
                ch = 1;
            push_item(MODE_QUERY, 0, $urandom_range(NC - 1), ch);
            if ($urandom_range(19) == 0)
                push_noise_load();
        end
        push_item(MODE_QUERY, $urandom_range(NE - 1), $urandom_range(NC - 1), CH_END);
    endfunction

    function automatic void random_phase(int n);
        int stop_at, r;
        stop_at = gen_count + n;
        while (gen_count < stop_at) begin
            r = $urandom_range(99);
            if (r < 12)
                load_word($urandom_range(NE - 1));
            else if (r < 20)
                push_noise_load();
            else
                push_query();
        end
    endfunction

    // ------------------------------------------------------------------
    // Phase control
    // ------------------------------------------------------------------
    // Write entry_count while idle; leave the task on a falling edge.
    task automatic set_entry_count(bit [4:0] v);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        model_count    = v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        @(negedge i_clk);
    endtask

    // Pause the sender until every word is taken and every result is back, then let any
    // query byte still in the core finish.
    task automatic drain_and_settle();
        @(negedge i_clk);
        while (pending_in_q.size() != 0 || s_axis_tvalid || expected_found_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        foreach (model_status[e])
            model_status[e] = spds_pkg::ST_EQUAL;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sender idles 38 %, receiver 63 %.
        tx_idle_pct = 38;
        rx_idle_pct = 63;
        set_entry_count(5'd16);

        // Directed: "ab", "b", 0xFF at both ends of the last entry, empty words between.
        push_item(MODE_LOAD, 0, 0, CH_A);
        push_item(MODE_LOAD, 0, 1, CH_A + 1);
        push_item(MODE_LOAD, 1, 0, CH_A + 1);
        push_item(MODE_LOAD, 15, 0, 8'hFF);
        push_item(MODE_LOAD, 15, 31, 8'hFF);
        push_item(MODE_QUERY, 0, 0, CH_END);               // empty query hits entry 0
        push_item(MODE_QUERY, 0, 0, CH_A);                 // prefix of "ab"
        push_item(MODE_QUERY, 0, 0, CH_END);
        push_item(MODE_QUERY, 0, 0, CH_A + 2);             // "c": stopped by 0xFF entry
        push_item(MODE_QUERY, 0, 0, CH_END);
        push_item(MODE_QUERY, 0, 0, CH_A);                 // "abc": entry ends first
        push_item(MODE_QUERY, 0, 0, CH_A + 1);
        push_item(MODE_QUERY, 0, 0, CH_A + 2);
        push_item(MODE_QUERY, 0, 0, CH_END);
        push_item(MODE_QUERY, 0, 0, CH_A + 1);             // "b" hits entry 1
        push_item(MODE_QUERY, 0, 0, CH_END);
        push_item(MODE_QUERY, 0, 0, CH_A);                 // rewrite entry 0 mid-query
        push_item(MODE_LOAD, 0, 1, 8'h78);
        push_item(MODE_QUERY, 0, 0, 8'h78);
        push_item(MODE_QUERY, 0, 0, CH_END);
        push_item(MODE_QUERY, 15, 31, 8'hFF);              // only the last entry matches
        push_item(MODE_QUERY, 15, 31, CH_END);
        push_item(MODE_QUERY, 0, 0, 8'h01);                // below entry 0, so the scan stops there
        push_item(MODE_QUERY, 0, 0, CH_END);
        drain_and_settle();

        // Empty table count: nothing can be found.
        set_entry_count(5'd0);
        push_item(MODE_QUERY, 0, 0, CH_END);
        push_item(MODE_QUERY, 0, 0, CH_A);
        push_item(MODE_QUERY, 0, 0, CH_END);
        drain_and_settle();

        // Count above the table size scans every entry.
        set_entry_count(5'd31);
        push_item(MODE_QUERY, 0, 0, 8'hFF);
        push_item(MODE_QUERY, 0, 0, CH_END);
        drain_and_settle();

        // Random: sorted dictionary, full count.
        set_entry_count(5'd16);
        load_sorted_table(NE);
        random_phase(80);
        drain_and_settle();

        set_entry_count(5'($urandom_range(1, NE - 1)));
        random_phase(60);
        drain_and_settle();

        // Back-pressure: the receiver stalls long enough for the core to block its input.
        set_entry_count(5'd16);
        random_phase(50);
        hold_go = 1'b1;
        drain_and_settle();

        // Swap the idle rates.
        tx_idle_pct = 63;
        rx_idle_pct = 38;
        begin
            int n;
            n = $urandom_range(4, 10);
            set_entry_count(5'(n));
            load_sorted_table(n);
        end
        random_phase(80);
        drain_and_settle();

        set_entry_count(5'd31);
        random_phase(50);
        drain_and_settle();

        // No idling on either side.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_entry_count(5'd0);
        random_phase(30);
        drain_and_settle();

        set_entry_count(5'd16);
        load_sorted_table(NE);
        random_phase(70);
        drain_and_settle();

        if (fail_count == 0 && expected_found_q.size() == 0)
            $display("PASS sorted_dictionary_prefix_search_core");
        else
            $display("FAIL sorted_dictionary_prefix_search_core");
        $finish;
    end

endmodule
